[rtl/core/deq_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// Double-ended queue package
// Shared sizes, operation codes and the control bundle for the cell chain.
// -----------------------------------------------------------------------------
package deq_pkg;

    // Number of cells in the chain.
    localparam int CAPACITY = 16;
    // Width of a cell index and of an occupancy count (which reaches CAPACITY).
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Fixed widths of the transaction fields.
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    // Operation requested by an input transaction.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_DUMP_FWD   = 3'd4,
        KIND_DUMP_REV   = 3'd5
    } t_kind;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // What every cell does with its data.
    typedef enum logic [2:0] {
        CELL_HOLD,       // keep the stored value
        CELL_FROM_LEFT,  // take the neighbor toward the front (shift to the back)
        CELL_FROM_RIGHT, // take the neighbor toward the back (shift to the front)
        CELL_ROT_FWD,    // shift to the front, the tail cell takes the load value
        CELL_LOAD_END    // the first free cell takes the load value
    } t_cell_op;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  load;
    } t_cell_ctl;

endpackage : deq_pkg
`default_nettype wire

[rtl/core/deq_cell.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// Double-ended queue cell
// One storage cell of the chain; it takes its neighbor's value, a broadcast
// load value, or keeps its own, as the broadcast control asks.
// -----------------------------------------------------------------------------
module deq_cell (
    input  wire                               i_clk,
    input  wire  deq_pkg::t_cell_ctl          i_ctl,
    input  wire                               i_at_tail,
    input  wire                               i_at_end,
    input  wire  signed [deq_pkg::DATA_W-1:0] i_left,
    input  wire  signed [deq_pkg::DATA_W-1:0] i_right,
    output logic signed [deq_pkg::DATA_W-1:0] o_data
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // Select the next value from the neighbors or the broadcast load.
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_FROM_LEFT:  n_data = i_left;
            CELL_FROM_RIGHT: n_data = i_right;
            CELL_ROT_FWD:    n_data = i_at_tail ? i_ctl.load : i_right;
            CELL_LOAD_END: begin
                if (i_at_end) begin
                    n_data = i_ctl.load;
                end
            end
            default:         n_data = r_data;
        endcase
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule : deq_cell
`default_nettype wire

[rtl/core/double_ended_queue_core.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit values held in a chain of cells, front at
// cell 0. Pushes, pops and dumps in either direction, with status results.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Fields
//  input    in         i_valid / o_stall   i_kind, i_value
//  output   out        o_valid / i_stall   o_data, o_status, o_count, o_last
//
// A push or pop puts its result in the output register.
// A dump of N entries first enters the dump state and then emits one entry per
// cycle while the output is free, rotating the chain by one cell per entry; the input is stalled meanwhile.
// The output register stalls the input only while it holds a result that is
// not taken. Reset empties the queue; stored values are not cleared.
// -----------------------------------------------------------------------------
module double_ended_queue_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [deq_pkg::KIND_W-1:0]         i_kind,
    input  wire  signed [deq_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [deq_pkg::DATA_W-1:0]  o_data,
    output logic [deq_pkg::STAT_W-1:0]         o_status,
    output logic [deq_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_last
);
    import deq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    t_state                   r_state,  n_state;
    logic [CNT_W-1:0]         r_occ,    n_occ;
    logic [CNT_W-1:0]         r_left,   n_left;
    logic                     r_rev,    n_rev;
    logic                     r_valid,  n_valid;
    logic signed [DATA_W-1:0] r_data,   n_data;
    t_status                  r_status, n_status;
    logic [COUNT_W-1:0]       r_count,  n_count;
    logic                     r_last,   n_last;

    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_cell [CAPACITY];
    logic signed [DATA_W-1:0] w_head;
    logic signed [DATA_W-1:0] w_tail;
    logic signed [DATA_W-1:0] w_left0;
    logic                     w_out_free;
    logic                     w_accept;

    // Handshake.
    assign w_out_free = !r_valid || !i_stall;
    assign o_stall    = !((r_state == ST_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;

    // Front value and the value of the last occupied cell.
    assign w_head = w_cell[0];
    always_comb begin
        w_tail = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (r_occ == CNT_W'(k + 1)) begin
                w_tail = w_cell[k];
            end
        end
    end

    // Control and result selection.
    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_left     = r_left;
        n_rev      = r_rev;
        n_valid    = r_valid && i_stall;
        n_data     = r_data;
        n_status   = r_status;
        n_count    = r_count;
        n_last     = r_last;
        w_ctl.op   = CELL_HOLD;
        // A forward rotation feeds the front value into the tail cell.
        w_ctl.load = (r_state == ST_DUMP) ? w_head : i_value;

        if (w_accept) begin
            unique case (t_kind'(i_kind))
                KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                    n_valid = 1'b1;
                    n_data  = '0;
                    n_last  = 1'b1;
                    if (r_occ == CNT_W'(CAPACITY)) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_ctl.op = (t_kind'(i_kind) == KIND_PUSH_FRONT) ?
                                   CELL_FROM_LEFT : CELL_LOAD_END;
                        n_occ    = r_occ + CNT_W'(1);
                        n_status = STAT_OK;
                    end
                    n_count = COUNT_W'(n_occ);
                end
                KIND_POP_FRONT, KIND_POP_BACK: begin
                    n_valid = 1'b1;
                    n_last  = 1'b1;
                    if (r_occ == '0) begin
                        n_data   = '0;
                        n_status = STAT_EMPTY;
                    end else begin
                        if (t_kind'(i_kind) == KIND_POP_FRONT) begin
                            w_ctl.op = CELL_FROM_RIGHT;
                            n_data   = w_head;
                        end else begin
                            n_data   = w_tail;
                        end
                        n_occ    = r_occ - CNT_W'(1);
                        n_status = STAT_OK;
                    end
                    n_count = COUNT_W'(n_occ);
                end
                KIND_DUMP_FWD, KIND_DUMP_REV: begin
                    if (r_occ == '0) begin
                        n_valid  = 1'b1;
                        n_data   = '0;
                        n_status = STAT_EMPTY;
                        n_count  = '0;
                        n_last   = 1'b1;
                    end else begin
                        n_state = ST_DUMP;
                        n_left  = r_occ;
                        n_rev   = (t_kind'(i_kind) == KIND_DUMP_REV);
                    end
                end
                default: begin
                    // Unused codes are taken and dropped.
                end
            endcase
        end else if (r_state == ST_DUMP && w_out_free) begin
            // Emit one entry and rotate the occupied part of the chain.
            w_ctl.op = r_rev ? CELL_FROM_LEFT : CELL_ROT_FWD;
            n_valid  = 1'b1;
            n_data   = r_rev ? w_tail : w_head;
            n_status = STAT_OK;
            n_count  = COUNT_W'(r_occ);
            n_last   = (r_left == CNT_W'(1));
            n_left   = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    // A reverse rotation feeds the tail into the front cell.
    assign w_left0 = (r_state == ST_DUMP) ? w_tail : i_value;

    // Cell chain.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_l;
        logic signed [DATA_W-1:0] w_r;
        if (g == 0) begin : g_first
            assign w_l = w_left0;
        end else begin : g_mid_l
            assign w_l = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_r = w_cell[g];
        end else begin : g_mid_r
            assign w_r = w_cell[g+1];
        end
        deq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_at_tail (r_occ == CNT_W'(g + 1)),
            .i_at_end  (r_occ == CNT_W'(g)),
            .i_left    (w_l),
            .i_right   (w_r),
            .o_data    (w_cell[g])
        );
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_occ    <= '0;
            r_left   <= '0;
            r_rev    <= 1'b0;
            r_valid  <= 1'b0;
            r_data   <= '0;
            r_status <= STAT_OK;
            r_count  <= '0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_left   <= n_left;
            r_rev    <= n_rev;
            r_valid  <= n_valid;
            r_data   <= n_data;
            r_status <= n_status;
            r_count  <= n_count;
            r_last   <= n_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_last   = r_last;

endmodule : double_ended_queue_core
`default_nettype wire
